// ===== rtl/lswa_pkg.sv =====
// ----------------------------------------------------------------------------
// lswa_pkg
// Shared types and constants of the light sample window averager.
// ----------------------------------------------------------------------------
package lswa_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int DIFF_W     = 11;
  localparam int SAMPLE_MAX = 1023;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;

  localparam sample_t RESET_LEVEL = sample_t'(600);

  // Default configuration of the block
  localparam int DEF_WINDOW      = 16;
  localparam int DEF_MEAN_DEPTH  = 8;
  localparam int DEF_MEAN_PERIOD = 4;
  localparam int DEF_PAST_LAG    = 5;

  // APB register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_GRAY_THRESHOLD = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_index_t;

endpackage

// ===== rtl/lswa_intf.sv =====
// ----------------------------------------------------------------------------
// lswa channel interfaces
// Valid/ready channels for light samples in and averaged results out.
// ----------------------------------------------------------------------------
interface lswa_sample_if;
  import lswa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink (input valid, input light_sample, output ready);
endinterface

interface lswa_result_if;
  import lswa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t newest_sample;
  diff_t   edge_difference;
  diff_t   past_difference;
  sample_t mean_of_means;

  modport source (
    output valid, output newest_sample, output edge_difference,
    output past_difference, output mean_of_means, input ready
  );
  modport sink (
    input valid, input newest_sample, input edge_difference,
    input past_difference, input mean_of_means, output ready
  );
endinterface

// ===== rtl/light_sample_window_averager.sv =====
// ----------------------------------------------------------------------------
// light_sample_window_averager
// Sliding window of light samples with a decimated history of window means.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle unless the input is stalled by a full
// pipeline, and each sample yields one result through three register stages: the window shift
// and running sum, then the window mean (one constant reciprocal multiply)
// pushed into the running mean history, then the mean of means (a second
// reciprocal multiply). Each stage accepts a new item whenever its own
// register is empty or moving on, so samples keep flowing while a finished
// result waits for the consumer. The gray threshold is an APB register at
// byte address 0 (reset 600); write it only while no samples are in flight.
module light_sample_window_averager #(
  parameter int WINDOW      = lswa_pkg::DEF_WINDOW,
  parameter int MEAN_DEPTH  = lswa_pkg::DEF_MEAN_DEPTH,
  parameter int MEAN_PERIOD = lswa_pkg::DEF_MEAN_PERIOD,
  parameter int PAST_LAG    = lswa_pkg::DEF_PAST_LAG
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lswa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lswa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lswa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  lswa_sample_if.sink                     samples,
  lswa_result_if.source                   results
);
  import lswa_pkg::*;

  localparam int LAG_SAT  = (PAST_LAG > WINDOW - 1) ? WINDOW - 1 : PAST_LAG;
  localparam int PAST_TAP = WINDOW - LAG_SAT;
  localparam int PCNT_W   = (MEAN_PERIOD > 1) ? $clog2(MEAN_PERIOD) : 1;

  localparam int WSUM_W = $clog2(SAMPLE_MAX * WINDOW + 1);
  localparam int WDIV_SHIFT = WSUM_W + $clog2(WINDOW);
  localparam longint unsigned WDIV_MULT =
    ((64'd1 << WDIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int WDIV_MULT_W = $clog2(WDIV_MULT + 1);
  localparam int WPROD_W = WSUM_W + WDIV_MULT_W;

  localparam int MSUM_W = $clog2(SAMPLE_MAX * MEAN_DEPTH + 1);
  localparam int MDIV_SHIFT = MSUM_W + $clog2(MEAN_DEPTH);
  localparam longint unsigned MDIV_MULT =
    ((64'd1 << MDIV_SHIFT) + MEAN_DEPTH - 1) / MEAN_DEPTH;
  localparam int MDIV_MULT_W = $clog2(MDIV_MULT + 1);
  localparam int MPROD_W = MSUM_W + MDIV_MULT_W;

  localparam logic [WSUM_W-1:0] WSUM_RESET = WSUM_W'(600 * WINDOW);
  localparam logic [MSUM_W-1:0] MSUM_RESET = MSUM_W'(600 * MEAN_DEPTH);
  localparam logic [WSUM_W-1:0] WSUM_MAX   = WSUM_W'(SAMPLE_MAX * WINDOW);
  localparam logic [MSUM_W-1:0] MSUM_MAX   = MSUM_W'(SAMPLE_MAX * MEAN_DEPTH);

  // Configuration
  sample_t gray_threshold;
  logic    cfg_write;

  // Architectural state
  sample_t             sample_history [WINDOW];
  logic [WSUM_W-1:0]   window_sum;
  logic [WSUM_W-1:0]   window_sum_next;
  sample_t             mean_history [MEAN_DEPTH];
  logic [MSUM_W-1:0]   mean_sum;
  logic [MSUM_W-1:0]   mean_sum_next;
  logic [PCNT_W-1:0]   period_count;

  // Pipeline stages
  logic    s1_valid, s2_valid, out_valid;
  sample_t s1_sample, s2_sample, out_sample;
  diff_t   s1_edge, s2_edge, out_edge;
  diff_t   s1_past, s2_past, out_past;
  logic    s1_take;
  sample_t out_mean;

  logic free3, free2, free1;
  logic load1, move12, move23;

  logic [WPROD_W-1:0] wdiv_prod;
  sample_t            window_mean;
  logic [MPROD_W-1:0] mdiv_prod;
  diff_t              edge_calc, past_calc;

  // APB register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (reg_index_t'(paddr[2]) == REG_GRAY_THRESHOLD);
  assign prdata    = (reg_index_t'(paddr[2]) == REG_GRAY_THRESHOLD) ?
                     APB_DATA_W'(gray_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= RESET_LEVEL;
    end else if (cfg_write) begin
      gray_threshold <= pwdata[SAMPLE_W-1:0];
    end
  end

  // Stage handshake: a stage loads when it is empty or its item moves on
  assign free3  = !out_valid || results.ready;
  assign free2  = !s2_valid || free3;
  assign free1  = !s1_valid || free2;
  assign load1  = samples.valid && free1;
  assign move12 = s1_valid && free2;
  assign move23 = s2_valid && free3;
  assign samples.ready = free1;

  // Stage 1: window shift, running sum, differences
  assign window_sum_next = window_sum - WSUM_W'(sample_history[0])
                           + WSUM_W'(samples.light_sample);
  assign edge_calc = diff_t'({1'b0, gray_threshold}) -
                     diff_t'({1'b0, samples.light_sample});
  assign past_calc = diff_t'({1'b0, sample_history[PAST_TAP]}) -
                     diff_t'({1'b0, samples.light_sample});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        sample_history[i] <= RESET_LEVEL;
      end
      window_sum   <= WSUM_RESET;
      period_count <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (load1) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          sample_history[i] <= sample_history[i+1];
        end
        sample_history[WINDOW-1] <= samples.light_sample;
        window_sum <= window_sum_next;
        if (period_count == PCNT_W'(MEAN_PERIOD - 1)) begin
          period_count <= '0;
        end else begin
          period_count <= period_count + PCNT_W'(1);
        end
        s1_valid <= 1'b1;
      end else if (move12) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_sample <= samples.light_sample;
      s1_edge   <= edge_calc;
      s1_past   <= past_calc;
      s1_take   <= (period_count == '0);
    end
  end

  // Stage 2: window mean into the mean history; window_sum belongs to s1's item
  assign wdiv_prod   = WPROD_W'(window_sum) * WPROD_W'(WDIV_MULT);
  assign window_mean = sample_t'(wdiv_prod >> WDIV_SHIFT);
  assign mean_sum_next = mean_sum - MSUM_W'(mean_history[0]) + MSUM_W'(window_mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEAN_DEPTH; i++) begin
        mean_history[i] <= RESET_LEVEL;
      end
      mean_sum <= MSUM_RESET;
      s2_valid <= 1'b0;
    end else begin
      if (move12) begin
        if (s1_take) begin
          for (int i = 0; i < MEAN_DEPTH - 1; i++) begin
            mean_history[i] <= mean_history[i+1];
          end
          mean_history[MEAN_DEPTH-1] <= window_mean;
          mean_sum <= mean_sum_next;
        end
        s2_valid <= 1'b1;
      end else if (move23) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move12) begin
      s2_sample <= s1_sample;
      s2_edge   <= s1_edge;
      s2_past   <= s1_past;
    end
  end

  // Stage 3: mean of the stored means into the result register
  assign mdiv_prod = MPROD_W'(mean_sum) * MPROD_W'(MDIV_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move23) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move23) begin
      out_sample <= s2_sample;
      out_edge   <= s2_edge;
      out_past   <= s2_past;
      out_mean   <= sample_t'(mdiv_prod >> MDIV_SHIFT);
    end
  end

  assign results.valid           = out_valid;
  assign results.newest_sample   = out_sample;
  assign results.edge_difference = out_edge;
  assign results.past_difference = out_past;
  assign results.mean_of_means   = out_mean;

  // Input stalls only when every stage holds an item and the result is stuck
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (s1_valid && s2_valid && out_valid && !results.ready))
    else $error("input stalled with a free pipeline stage");

  a_window_sum_range: assert property (@(posedge clk) disable iff (rst)
    window_sum <= WSUM_MAX)
    else $error("window sum out of range");

  a_mean_sum_range: assert property (@(posedge clk) disable iff (rst)
    mean_sum <= MSUM_MAX)
    else $error("mean history sum out of range");

endmodule

// ===== tb/tb_light_sample_window_averager.sv =====
// ----------------------------------------------------------------------------
// tb_light_sample_window_averager
// Self-checking bench for the light sample window averager. A queue-fed
// driver offers samples with random gaps, a monitor takes results with random
// back-pressure, and a local model of the sample window, the decimated mean
// history and the gray threshold predicts every result field.
// ----------------------------------------------------------------------------
module tb_light_sample_window_averager;
  import lswa_pkg::*;

  localparam int WIN          = DEF_WINDOW;
  localparam int MEANS        = DEF_MEAN_DEPTH;
  localparam int PERIOD       = DEF_MEAN_PERIOD;
  localparam int LAG          = (DEF_PAST_LAG > DEF_WINDOW - 1) ? DEF_WINDOW - 1 : DEF_PAST_LAG;
  localparam int IDLE_PCT     = 23;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int BURST_ITEMS  = 216;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t newest_sample;
    diff_t   edge_difference;
    diff_t   past_difference;
    sample_t mean_of_means;
  } light_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lswa_sample_if sample_ch ();
  lswa_result_if result_ch ();

  light_sample_window_averager i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (sample_ch),
    .results (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  sample_t window_q [WIN];
  int      window_total;
  sample_t mean_q [MEANS];
  int      decim_count;
  sample_t gray_level;

  sample_t       pending_samples [$];
  light_result_t predicted_results [$];

  bit steady;        // suppress random gaps on both sides
  bit hold_pending;  // ask the monitor for one long hold-off
  int hold_left;
  int mismatch_count;
  int samples_sent;
  int results_checked;
  int stall_cycles;

  function automatic light_result_t advance_window(input sample_t s);
    light_result_t r;
    int            msum;
    msum = 0;
    window_total -= int'(window_q[0]);
    for (int i = 0; i < WIN - 1; i++) window_q[i] = window_q[i + 1];
    window_q[WIN - 1] = s;
    window_total += int'(s);
    if (decim_count == 0) begin
      for (int i = 0; i < MEANS - 1; i++) mean_q[i] = mean_q[i + 1];
      mean_q[MEANS - 1] = sample_t'(window_total / WIN);
    end
    decim_count = (decim_count + 1) % PERIOD;
    for (int i = 0; i < MEANS; i++) msum += int'(mean_q[i]);
    r.newest_sample   = s;
    r.edge_difference = diff_t'(int'(gray_level) - int'(s));
    r.past_difference = diff_t'(int'(window_q[WIN - 1 - LAG]) - int'(s));
    r.mean_of_means   = sample_t'(msum / MEANS);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DIFF_W-1:0] want,
                             input logic [DIFF_W-1:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("mismatch on %s at result %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: offer the head of the pending queue, hold it until transfer
  always @(posedge clk) begin : drive_proc
    light_result_t predicted;
    sample_t       taken;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        taken     = pending_samples.pop_front();
        predicted = advance_window(taken);
        predicted_results.push_back(predicted);
        samples_sent++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() > 0 &&
            (steady || $urandom_range(99) >= IDLE_PCT)) begin
          sample_ch.valid        <= 1'b1;
          sample_ch.light_sample <= pending_samples[0];
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transfer against the oldest prediction
  always @(posedge clk) begin : check_proc
    light_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("unexpected result: sample %0h, no prediction waiting",
                     result_ch.newest_sample);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("newest_sample", DIFF_W'(want.newest_sample),
                      DIFF_W'(result_ch.newest_sample));
          check_field("edge_difference", want.edge_difference, result_ch.edge_difference);
          check_field("past_difference", want.past_difference, result_ch.past_difference);
          check_field("mean_of_means", DIFF_W'(want.mean_of_means),
                      DIFF_W'(result_ch.mean_of_means));
        end
        results_checked++;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left       <= hold_left - 1;
      end else if (hold_pending) begin
        hold_pending    <= 1'b0;
        hold_left       <= HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || psel || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Upper bits are dropped by the register
    if (idx == REG_GRAY_THRESHOLD) gray_level = data[SAMPLE_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || predicted_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random content: single uniform values mixed with runs of extremes, constant
  // levels and ramps so the window and mean history reach their limits
  task automatic queue_random_burst(input int count);
    int      left;
    int      run;
    int      mode;
    sample_t level;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(9);
      run  = (mode < 5) ? 1 : $urandom_range(40, 1);
      if (run > left) run = left;
      level = (mode == 6) ? sample_t'(SAMPLE_MAX * $urandom_range(1))
                          : sample_t'($urandom_range(SAMPLE_MAX));
      for (int i = 0; i < run; i++) begin
        case (mode)
          0, 1, 2, 3, 4: pending_samples.push_back(sample_t'($urandom_range(SAMPLE_MAX)));
          5:             pending_samples.push_back($urandom_range(1) ? sample_t'(SAMPLE_MAX)
                                                                     : sample_t'(0));
          6, 7:          pending_samples.push_back(level);
          default:       pending_samples.push_back(level + sample_t'(i * 29));
        endcase
      end
      left -= run;
    end
  endtask

  initial begin
    sample_t directed [] = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1, 10'd1022,
                             10'd600, 10'd599, 10'd601, 10'd512, 10'd511, 10'd0,
                             10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                             10'd1023, 10'd0, 10'd0, 10'd341, 10'd682};
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.light_sample = '0;
    result_ch.ready        = 1'b0;
    steady                 = 1'b0;
    hold_pending           = 1'b0;
    mismatch_count         = 0;
    samples_sent           = 0;
    results_checked        = 0;
    gray_level             = RESET_LEVEL;
    window_total           = int'(RESET_LEVEL) * WIN;
    decim_count            = 0;
    for (int i = 0; i < WIN; i++) window_q[i] = RESET_LEVEL;
    for (int i = 0; i < MEANS; i++) mean_q[i] = RESET_LEVEL;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset threshold, field extremes and decimation boundaries
    foreach (directed[i]) pending_samples.push_back(directed[i]);
    wait_idle();

    // Threshold at its floor, garbage in the upper bits; unused register
    apb_write(REG_GRAY_THRESHOLD, 32'hFFFF_FC00);
    apb_write(REG_UNUSED, $urandom);
    queue_random_burst(BURST_ITEMS);
    wait_idle();

    // Threshold at its ceiling; stall the output so the pipeline backs up
    apb_write(REG_GRAY_THRESHOLD, 32'h0000_03FF);
    queue_random_burst(BURST_ITEMS);
    hold_pending = 1'b1;
    wait_idle();

    // Random threshold, no gaps on either side
    apb_write(REG_GRAY_THRESHOLD, $urandom);
    steady = 1'b1;
    queue_random_burst(BURST_ITEMS);
    wait_idle();
    steady = 1'b0;

    apb_write(REG_GRAY_THRESHOLD, $urandom);
    queue_random_burst(BURST_ITEMS);
    hold_pending = 1'b1;
    wait_idle();

    apb_write(REG_GRAY_THRESHOLD, $urandom_range(SAMPLE_MAX));
    queue_random_burst(BURST_ITEMS);
    wait_idle();

    $display("%0d samples sent and %0d results checked over six threshold settings,",
             samples_sent, results_checked);
    $display("including both threshold extremes, a gap-free phase and two output hold-offs");
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count,
               predicted_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
